/* hw/rtl/rau_pkg.sv */
`timescale 1ns / 1ps

package rau_pkg;

    // Working width of every value inside the unit (8 .. 32)
    localparam int VALUE_W     = 32;
    // Fixed widths of the item fields
    localparam int FIELD_W     = 32;
    localparam int DEN_FIELD_W = 31;
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int CNT_W       = $clog2(VALUE_W);
    localparam int MUL_STEPS   = 3;

    typedef enum logic [2:0] {
        OP_NORM    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_LESS    = 3'd5,
        OP_GREATER = 3'd6,
        OP_EQUAL   = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_DIV_ZERO = 2'd2,
        STAT_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CANL_GO,
        S_CANL_WAIT,
        S_CANR_GO,
        S_CANR_WAIT,
        S_MUL,
        S_SUM,
        S_EVAL,
        S_CANZ_GO,
        S_CANZ_WAIT,
        S_DONE
    } t_main_state;

    typedef enum logic [2:0] {
        CN_IDLE,
        CN_GCD_GO,
        CN_GCD_WAIT,
        CN_DIVN_GO,
        CN_DIVN_WAIT,
        CN_DIVD_GO,
        CN_DIVD_WAIT,
        CN_FIX
    } t_canon_state;

    // Canonical fraction handed back by the reduce unit
    typedef struct packed {
        logic                        done;
        logic                        ovf;
        logic signed [VALUE_W-1:0]   num;
        logic        [VALUE_W-2:0]   den;
    } t_canon_res;

endpackage

/* hw/rtl/rau_gcd.sv */
`timescale 1ns / 1ps

module rau_gcd (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rau_pkg::VALUE_W-1:0]    i_a,
    input  logic [rau_pkg::VALUE_W-1:0]    i_b,
    output logic                           o_done,
    output logic [rau_pkg::VALUE_W-1:0]    o_gcd
);
    import rau_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [VALUE_W-1:0] r_x;
    logic [VALUE_W-1:0] r_y;
    logic [CNT_W-1:0]   r_k;
    logic [VALUE_W-1:0] r_gcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_x == '0 || r_y == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // One binary gcd step per cycle: common halving, single halving or subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_a;
            r_y <= i_b;
            r_k <= '0;
        end else if (r_busy) begin
            if (r_x == '0 || r_y == '0) begin
                r_gcd <= (r_x | r_y) << r_k;
            end else if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x > r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_gcd;

endmodule

/* hw/rtl/rau_div.sv */
`timescale 1ns / 1ps

module rau_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rau_pkg::VALUE_W-1:0]    i_dividend,
    input  logic [rau_pkg::VALUE_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [rau_pkg::VALUE_W-1:0]    o_quotient
);
    import rau_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] r_quo;
    logic [VALUE_W-1:0] r_dvs;
    logic [VALUE_W:0]   w_rem_sh;
    logic [VALUE_W:0]   w_diff;
    logic               w_fit;
    logic               w_last;

    assign w_rem_sh = {r_rem, r_quo[VALUE_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_fit    = (w_rem_sh >= {1'b0, r_dvs});
    assign w_last   = (r_cnt == CNT_W'(VALUE_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_fit) begin
                r_rem <= w_diff[VALUE_W-1:0];
                r_quo <= {r_quo[VALUE_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[VALUE_W-1:0];
                r_quo <= {r_quo[VALUE_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/rau_canon.sv */
`timescale 1ns / 1ps

module rau_canon (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [rau_pkg::VALUE_W-1:0]  i_num,
    input  logic signed [rau_pkg::VALUE_W-1:0]  i_den,
    output rau_pkg::t_canon_res                 o_res
);
    import rau_pkg::*;

    t_canon_state       r_state;
    t_canon_state       n_state;
    logic               r_neg;
    logic [VALUE_W-1:0] r_mn;
    logic [VALUE_W-1:0] r_md;
    logic [VALUE_W-1:0] r_g;
    logic [VALUE_W-1:0] r_qn;
    logic [VALUE_W-1:0] r_qd;

    logic               w_gcd_start;
    logic               w_gcd_done;
    logic [VALUE_W-1:0] w_gcd;
    logic               w_div_start;
    logic               w_div_done;
    logic [VALUE_W-1:0] w_dividend;
    logic [VALUE_W-1:0] w_quo;
    logic [VALUE_W-1:0] w_mag_num;
    logic [VALUE_W-1:0] w_mag_den;

    assign w_mag_num = i_num[VALUE_W-1] ? VALUE_W'(-i_num) : VALUE_W'(i_num);
    assign w_mag_den = i_den[VALUE_W-1] ? VALUE_W'(-i_den) : VALUE_W'(i_den);

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (r_mn),
        .i_b     (r_md),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_g),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            CN_IDLE:      if (i_start) n_state = CN_GCD_GO;
            CN_GCD_GO:    n_state = CN_GCD_WAIT;
            CN_GCD_WAIT:  if (w_gcd_done) n_state = CN_DIVN_GO;
            CN_DIVN_GO:   n_state = CN_DIVN_WAIT;
            CN_DIVN_WAIT: if (w_div_done) n_state = CN_DIVD_GO;
            CN_DIVD_GO:   n_state = CN_DIVD_WAIT;
            CN_DIVD_WAIT: if (w_div_done) n_state = CN_FIX;
            CN_FIX:       n_state = CN_IDLE;
            default:      n_state = CN_IDLE;
        endcase
    end

    always_comb begin
        w_gcd_start = (r_state == CN_GCD_GO);
        w_div_start = (r_state == CN_DIVN_GO) || (r_state == CN_DIVD_GO);
        w_dividend  = (r_state == CN_DIVN_GO) ? r_mn : r_md;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CN_IDLE: begin
                if (i_start) begin
                    r_neg <= i_num[VALUE_W-1] ^ i_den[VALUE_W-1];
                    r_mn  <= w_mag_num;
                    r_md  <= w_mag_den;
                end
            end
            CN_GCD_WAIT:  if (w_gcd_done) r_g <= w_gcd;
            CN_DIVN_WAIT: if (w_div_done) r_qn <= w_quo;
            CN_DIVD_WAIT: if (w_div_done) r_qd <= w_quo;
            default: ;
        endcase
    end

    // Sign goes onto the numerator; a magnitude past the signed range overflows
    always_comb begin
        o_res.done = (r_state == CN_FIX);
        o_res.num  = r_neg ? -$signed(r_qn) : $signed(r_qn);
        o_res.den  = r_qd[VALUE_W-2:0];
        o_res.ovf  = r_qd[VALUE_W-1]
                   | (r_neg ? (r_qn[VALUE_W-1] && (|r_qn[VALUE_W-2:0])) : r_qn[VALUE_W-1]);
    end

endmodule

/* hw/rtl/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps

// Rational arithmetic unit: normalize, add, sub, mul, div and compare of
// two fractions, every arithmetic result reduced to lowest terms.
// Input channel: i_in_valid / o_in_stall with opcode and the two fractions.
// o_in_stall is high while an item is in work; one item at a time.
// Output channel: o_out_valid / i_out_stall, one result per item, held in
// an output register, so a new item is taken while a result still waits.
// Each item runs up to three reduce passes besides the control states. A
// reduce pass is a binary gcd and then two restoring divides by the gcd,
// one for the numerator and one for the denominator, all in the shared
// reduce unit. Normalize takes one pass and equal two; less and greater
// take two passes and the three steps on the shared multiplier; add, sub,
// mul and div take three passes and the three multiplier steps. A zero
// denominator ends the item at the check, before any pass, and other
// errors end it after the reduce pass or range check that finds them.
// The next item is taken in the cycle after the result is loaded. A
// stalled receiver holds the finished item in the last state until the
// output register frees up. Synchronous active-low reset returns to idle
// and drops any pending result.
module rational_arithmetic_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic [2:0]                               i_opcode,
    input  logic signed [rau_pkg::FIELD_W-1:0]       i_lhs_num,
    input  logic signed [rau_pkg::FIELD_W-1:0]       i_lhs_den,
    input  logic signed [rau_pkg::FIELD_W-1:0]       i_rhs_num,
    input  logic signed [rau_pkg::FIELD_W-1:0]       i_rhs_den,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [rau_pkg::FIELD_W-1:0]       o_result_num,
    output logic [rau_pkg::DEN_FIELD_W-1:0]          o_result_den,
    output logic                                     o_compare_true,
    output logic [1:0]                               o_status
);
    import rau_pkg::*;

    t_main_state               r_state;
    t_main_state               n_state;
    t_opcode                   r_op;
    logic signed [VALUE_W-1:0] r_a;
    logic signed [VALUE_W-1:0] r_b;
    logic signed [VALUE_W-1:0] r_c;
    logic signed [VALUE_W-1:0] r_d;
    logic signed [PROD_W-1:0]  r_p0;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic signed [PROD_W-1:0]  r_un;
    logic [1:0]                r_step;
    t_status                   r_status;
    logic                      r_cmp;
    logic signed [VALUE_W-1:0] r_rnum;
    logic [VALUE_W-2:0]        r_rden;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_num;
    logic [VALUE_W-2:0]        r_out_den;
    logic                      r_out_cmp;
    t_status                   r_out_status;

    logic                      w_accept;
    logic                      w_in_stall;
    logic                      w_out_load;
    logic                      w_canon_start;
    logic signed [VALUE_W-1:0] w_canon_num;
    logic signed [VALUE_W-1:0] w_canon_den;
    t_canon_res                w_cres;
    logic signed [VALUE_W-1:0] w_cres_den;
    logic                      w_zero_den;
    logic                      w_mul_last;
    logic                      w_un_range;
    logic                      w_ud_range;
    logic                      w_ok;
    logic signed [VALUE_W-1:0] w_mul_x;
    logic signed [VALUE_W-1:0] w_mul_y;
    logic signed [PROD_W-1:0]  w_prod;

    rau_canon u_canon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_canon_start),
        .i_num   (w_canon_num),
        .i_den   (w_canon_den),
        .o_res   (w_cres)
    );

    assign w_cres_den = $signed({1'b0, w_cres.den});
    assign w_zero_den = (r_b == '0) || (r_op != OP_NORM && r_d == '0);
    assign w_mul_last = (r_step == 2'(MUL_STEPS - 1));
    assign w_un_range = (&r_un[PROD_W-1:VALUE_W-1]) || !(|r_un[PROD_W-1:VALUE_W-1]);
    assign w_ud_range = (&r_p2[PROD_W-1:VALUE_W-1]) || !(|r_p2[PROD_W-1:VALUE_W-1]);
    assign w_ok       = (r_status == STAT_OK);

    // Shared multiplier: step 0 a*d (a*c for mul), step 1 c*b,
    // step 2 b*d (b*c for div)
    always_comb begin
        case (r_step)
            2'd0: begin
                w_mul_x = r_a;
                w_mul_y = (r_op == OP_MUL) ? r_c : r_d;
            end
            2'd1: begin
                w_mul_x = r_c;
                w_mul_y = r_b;
            end
            default: begin
                w_mul_x = r_b;
                w_mul_y = (r_op == OP_DIV) ? r_c : r_d;
            end
        endcase
    end
    assign w_prod = w_mul_x * w_mul_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (w_accept) n_state = S_CHECK;
            S_CHECK:     n_state = w_zero_den ? S_DONE : S_CANL_GO;
            S_CANL_GO:   n_state = S_CANL_WAIT;
            S_CANL_WAIT: begin
                if (w_cres.done) begin
                    n_state = (w_cres.ovf || r_op == OP_NORM) ? S_DONE : S_CANR_GO;
                end
            end
            S_CANR_GO:   n_state = S_CANR_WAIT;
            S_CANR_WAIT: begin
                if (w_cres.done) begin
                    if (w_cres.ovf || r_op == OP_EQUAL
                        || (r_op == OP_DIV && w_cres.num == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL:       if (w_mul_last) n_state = S_SUM;
            S_SUM:       n_state = S_EVAL;
            S_EVAL: begin
                if (r_op == OP_LESS || r_op == OP_GREATER) begin
                    n_state = S_DONE;
                end else if (!w_un_range || !w_ud_range) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CANZ_GO;
                end
            end
            S_CANZ_GO:   n_state = S_CANZ_WAIT;
            S_CANZ_WAIT: if (w_cres.done) n_state = S_DONE;
            S_DONE:      if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_stall    = (r_state != S_IDLE);
        w_accept      = i_in_valid && !w_in_stall;
        w_canon_start = (r_state == S_CANL_GO) || (r_state == S_CANR_GO)
                      || (r_state == S_CANZ_GO);
        w_out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
        case (r_state)
            S_CANR_GO: begin
                w_canon_num = r_c;
                w_canon_den = r_d;
            end
            S_CANZ_GO: begin
                w_canon_num = r_un[VALUE_W-1:0];
                w_canon_den = r_p2[VALUE_W-1:0];
            end
            default: begin
                w_canon_num = r_a;
                w_canon_den = r_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op     <= t_opcode'(i_opcode);
                    r_a      <= i_lhs_num[VALUE_W-1:0];
                    r_b      <= i_lhs_den[VALUE_W-1:0];
                    r_c      <= i_rhs_num[VALUE_W-1:0];
                    r_d      <= i_rhs_den[VALUE_W-1:0];
                    r_status <= STAT_OK;
                    r_cmp    <= 1'b0;
                    r_rnum   <= '0;
                    r_rden   <= (VALUE_W-1)'(1);
                end
            end
            S_CHECK: if (w_zero_den) r_status <= STAT_ZERO_DEN;
            S_CANL_WAIT: begin
                if (w_cres.done) begin
                    if (w_cres.ovf) begin
                        r_status <= STAT_OVERFLOW;
                    end else begin
                        r_a <= w_cres.num;
                        r_b <= w_cres_den;
                        if (r_op == OP_NORM) begin
                            r_rnum <= w_cres.num;
                            r_rden <= w_cres.den;
                        end
                    end
                end
            end
            S_CANR_WAIT: begin
                if (w_cres.done) begin
                    r_step <= '0;
                    if (w_cres.ovf) begin
                        r_status <= STAT_OVERFLOW;
                    end else begin
                        r_c <= w_cres.num;
                        r_d <= w_cres_den;
                        if (r_op == OP_EQUAL) begin
                            r_cmp <= (r_a == w_cres.num) && (r_b == w_cres_den);
                        end
                        if (r_op == OP_DIV && w_cres.num == '0) begin
                            r_status <= STAT_DIV_ZERO;
                        end
                    end
                end
            end
            S_MUL: begin
                r_step <= r_step + 1'b1;
                case (r_step)
                    2'd0:    r_p0 <= w_prod;
                    2'd1:    r_p1 <= w_prod;
                    default: r_p2 <= w_prod;
                endcase
            end
            S_SUM: begin
                case (r_op)
                    OP_ADD:         r_un <= r_p0 + r_p1;
                    OP_MUL, OP_DIV: r_un <= r_p0;
                    default:        r_un <= r_p0 - r_p1;
                endcase
            end
            S_EVAL: begin
                if (r_op == OP_LESS) begin
                    r_cmp <= r_un[PROD_W-1];
                end else if (r_op == OP_GREATER) begin
                    r_cmp <= !r_un[PROD_W-1] && (|r_un);
                end else if (!w_un_range || !w_ud_range) begin
                    r_status <= STAT_OVERFLOW;
                end
            end
            S_CANZ_WAIT: begin
                if (w_cres.done) begin
                    if (w_cres.ovf) begin
                        r_status <= STAT_OVERFLOW;
                    end else begin
                        r_rnum <= w_cres.num;
                        r_rden <= w_cres.den;
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register: take a finished item, release on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_num    <= w_ok ? r_rnum : '0;
            r_out_den    <= w_ok ? r_rden : (VALUE_W-1)'(1);
            r_out_cmp    <= w_ok && r_cmp;
        end
    end

    assign o_in_stall     = w_in_stall;
    assign o_out_valid    = r_out_valid;
    assign o_result_num   = FIELD_W'(r_out_num);
    assign o_result_den   = DEN_FIELD_W'(r_out_den);
    assign o_compare_true = r_out_cmp;
    assign o_status       = r_out_status;

endmodule

/* dv/rau_result_checker.sv */
`timescale 1ns / 1ps

module rau_result_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic [2:0]                             i_opcode,
    input  logic [rau_pkg::FIELD_W-1:0]            i_lhs_num,
    input  logic [rau_pkg::FIELD_W-1:0]            i_lhs_den,
    input  logic [rau_pkg::FIELD_W-1:0]            i_rhs_num,
    input  logic [rau_pkg::FIELD_W-1:0]            i_rhs_den,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic signed [rau_pkg::FIELD_W-1:0]     i_result_num,
    input  logic [rau_pkg::DEN_FIELD_W-1:0]        i_result_den,
    input  logic                                   i_compare_true,
    input  logic [1:0]                             i_status,
    output int                                     o_mismatches,
    output int                                     o_outstanding
);
    import rau_pkg::*;

    localparam longint VAL_MAX = (longint'(1) <<< (VALUE_W - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] num;
        logic [DEN_FIELD_W-1:0]    den;
        logic                      cmp;
        t_status                   st;
    } t_fraction_result;

    t_fraction_result awaited_results[$];
    int               mismatch_total = 0;

    // Keep the low VALUE_W bits and sign-extend them
    function automatic longint to_value(input logic [FIELD_W-1:0] raw);
        longint v;
        v = longint'({{(64 - FIELD_W){1'b0}}, raw}) & ((longint'(1) <<< VALUE_W) - 1);
        if (raw[VALUE_W-1]) v = v - (longint'(1) <<< VALUE_W);
        return v;
    endfunction

    function automatic bit fits_value(input longint v);
        return v >= VAL_MIN && v <= VAL_MAX;
    endfunction

    // Lowest terms with a positive denominator; returns 1 on overflow
    function automatic bit reduce_fraction(input longint n, input longint d,
                                           output longint qn, output longint qd);
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        x = (n < 0) ? -n : n;
        y = (d < 0) ? -d : d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        qn = n / longint'(x);
        qd = d / longint'(x);
        if (qd < 0) begin
            qn = -qn;
            qd = -qd;
        end
        return !(fits_value(qn) && fits_value(qd));
    endfunction

    function automatic t_fraction_result predict_result(input logic [2:0] op_bits,
                                                        input logic [FIELD_W-1:0] ln,
                                                        input logic [FIELD_W-1:0] ld,
                                                        input logic [FIELD_W-1:0] rn,
                                                        input logic [FIELD_W-1:0] rd);
        t_opcode          op;
        longint           a;
        longint           b;
        longint           c;
        longint           d;
        longint           un;
        longint           ud;
        longint           qn;
        longint           qd;
        longint           diff;
        t_fraction_result r;
        op = t_opcode'(op_bits);
        a = to_value(ln);
        b = to_value(ld);
        c = to_value(rn);
        d = to_value(rd);
        r.num = '0;
        r.den = DEN_FIELD_W'(1);
        r.cmp = 1'b0;
        r.st  = STAT_OK;
        un = 0;
        ud = 1;

        // Zero denominators win over everything; rhs is ignored for normalize
        if (b == 0 || (op != OP_NORM && d == 0)) begin
            r.st = STAT_ZERO_DEN;
        end else if (reduce_fraction(a, b, a, b)) begin
            r.st = STAT_OVERFLOW;
        end else if (op != OP_NORM && reduce_fraction(c, d, c, d)) begin
            r.st = STAT_OVERFLOW;
        end

        if (r.st == STAT_OK) begin
            diff = a * d - c * b;
            case (op)
                OP_NORM: begin
                    r.num = FIELD_W'(a);
                    r.den = DEN_FIELD_W'(b);
                end
                OP_ADD: begin
                    un = a * d + c * b;
                    ud = b * d;
                end
                OP_SUB: begin
                    un = diff;
                    ud = b * d;
                end
                OP_MUL: begin
                    un = a * c;
                    ud = b * d;
                end
                OP_DIV: begin
                    if (c == 0) begin
                        r.st = STAT_DIV_ZERO;
                    end else begin
                        un = a * d;
                        ud = b * c;
                    end
                end
                OP_LESS:    r.cmp = (diff < 0);
                OP_GREATER: r.cmp = (diff > 0);
                default:    r.cmp = (a == c && b == d);
            endcase
            if (r.st == STAT_OK && op >= OP_ADD && op <= OP_DIV) begin
                if (!fits_value(un) || !fits_value(ud)) begin
                    r.st = STAT_OVERFLOW;
                end else if (reduce_fraction(un, ud, qn, qd)) begin
                    r.st = STAT_OVERFLOW;
                end else begin
                    r.num = FIELD_W'(qn);
                    r.den = DEN_FIELD_W'(qd);
                end
            end
        end

        if (r.st != STAT_OK) begin
            r.num = '0;
            r.den = DEN_FIELD_W'(1);
            r.cmp = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fraction_result want;
        if (i_rst_n) begin
            // Retire the output transfer first: it can never belong to an item taken now
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: num %0d den %0d",
                           i_result_num, i_result_den);
                    mismatch_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result_num !== want.num) begin
                        $error("result_num: expected %0d, actual %0d", want.num, i_result_num);
                        mismatch_total++;
                    end
                    if (i_result_den !== want.den) begin
                        $error("result_den: expected %0d, actual %0d", want.den, i_result_den);
                        mismatch_total++;
                    end
                    if (i_compare_true !== want.cmp) begin
                        $error("compare_true: expected %0d, actual %0d",
                               want.cmp, i_compare_true);
                        mismatch_total++;
                    end
                    if (i_status !== want.st) begin
                        $error("status: expected %0d, actual %0d", want.st, i_status);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(predict_result(i_opcode, i_lhs_num, i_lhs_den,
                                                         i_rhs_num, i_rhs_den));
            end
        end
        o_outstanding <= awaited_results.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import rau_pkg::*;

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          SETTLE_CYCLES = 600;
    localparam int          RANDOM_PER_PHASE = 133;
    localparam logic [31:0] MIN_V = 32'h8000_0000;
    localparam logic [31:0] MAX_V = 32'h7fff_ffff;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [2:0]                  opcode = '0;
    logic [FIELD_W-1:0]          lhs_num = '0;
    logic [FIELD_W-1:0]          lhs_den = '0;
    logic [FIELD_W-1:0]          rhs_num = '0;
    logic [FIELD_W-1:0]          rhs_den = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [FIELD_W-1:0]   result_num;
    logic [DEN_FIELD_W-1:0]      result_den;
    logic                        compare_true;
    logic [1:0]                  status;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int send_pct = 22;
    int recv_pct = 87;
    int send_mix[3] = '{22, 87, 0};
    int recv_mix[3] = '{87, 22, 0};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rational_arithmetic_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_lhs_num      (lhs_num),
        .i_lhs_den      (lhs_den),
        .i_rhs_num      (rhs_num),
        .i_rhs_den      (rhs_den),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_num   (result_num),
        .o_result_den   (result_den),
        .o_compare_true (compare_true),
        .o_status       (status)
    );

    rau_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_lhs_num      (lhs_num),
        .i_lhs_den      (lhs_den),
        .i_rhs_num      (rhs_num),
        .i_rhs_den      (rhs_den),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result_num   (result_num),
        .i_result_den   (result_den),
        .i_compare_true (compare_true),
        .i_status       (status),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly values whose products stay in range, some full width and corner values
    function automatic logic [31:0] pick_value(input bit for_den);
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(30) * (1 << $urandom_range(4)) * ($urandom_range(2) + 1);
            3, 4:    v = $urandom_range(46340);
            5:       v = $urandom_range(32'h00ff_ffff);
            6, 7:    v = $urandom;
            8: begin
                case ($urandom_range(4))
                    0:       v = MIN_V;
                    1:       v = MAX_V;
                    2:       v = MIN_V + 1;
                    3:       v = 32'd1;
                    default: v = '0;
                endcase
            end
            default: v = $urandom_range(4);
        endcase
        if ($urandom_range(1)) v = -v;
        // keep zero denominators rare
        if (for_den && v == 0 && $urandom_range(15) != 0) v = $urandom_range(9) + 1;
        return v;
    endfunction

    task automatic send_item(input t_opcode op, input logic [31:0] ln, input logic [31:0] ld,
                             input logic [31:0] rn, input logic [31:0] rd);
        while ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        lhs_num  <= ln;
        lhs_den  <= ld;
        rhs_num  <= rn;
        rhs_den  <= rd;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_random_item();
        t_opcode     op;
        logic [31:0] ln;
        logic [31:0] ld;
        logic [31:0] rn;
        logic [31:0] rd;
        int          k;
        op = t_opcode'($urandom_range(7));
        ln = pick_value(1'b0);
        ld = pick_value(1'b1);
        rn = pick_value(1'b0);
        rd = pick_value(1'b1);
        if (op >= OP_LESS && $urandom_range(2) == 0) begin
            // scaled copy of the left fraction: equal value, different form
            k = $urandom_range(6) + 1;
            if ($urandom_range(1)) k = -k;
            rn = ln * k;
            rd = ld * k;
        end else if (op == OP_DIV && $urandom_range(7) == 0) begin
            rn = '0;
        end
        send_item(op, ln, ld, rn, rd);
    endtask

    // Hold the sender until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_NORM,    6,      -4,     0,      0);
        send_item(OP_NORM,    0,      -5,     3,      7);
        send_item(OP_NORM,    1,      MIN_V,  1,      1);
        send_item(OP_NORM,    MIN_V,  -1,     1,      1);
        send_item(OP_NORM,    MAX_V,  MAX_V,  1,      1);
        send_item(OP_NORM,    5,      0,      1,      1);
        send_item(OP_ADD,     1,      2,      1,      3);
        send_item(OP_ADD,     1,      2,      1,      0);
        send_item(OP_ADD,     MAX_V,  1,      MAX_V,  1);
        send_item(OP_SUB,     1,      3,      1,      3);
        send_item(OP_SUB,     MIN_V,  1,      1,      1);
        send_item(OP_MUL,     -2,     3,      3,      -4);
        send_item(OP_MUL,     65536,  1,      65536,  1);
        send_item(OP_DIV,     3,      4,      0,      7);
        send_item(OP_DIV,     MIN_V,  1,      -1,     1);
        send_item(OP_DIV,     -7,     3,      14,     9);
        send_item(OP_LESS,    MIN_V,  1,      MAX_V,  1);
        send_item(OP_LESS,    1,      2,      2,      4);
        send_item(OP_LESS,    1,      MIN_V,  1,      2);
        send_item(OP_GREATER, MAX_V,  1,      MIN_V,  1);
        send_item(OP_GREATER, -1,     3,      -1,     2);
        send_item(OP_EQUAL,   2,      4,      -1,     -2);
        send_item(OP_EQUAL,   0,      5,      0,      -3);
        send_item(OP_EQUAL,   1,      3,      1,      4);
        send_item(OP_EQUAL,   MAX_V,  -1,     MIN_V + 1, 1);

        for (int phase = 0; phase < 3; phase++) begin
            send_pct = send_mix[phase];
            recv_pct = recv_mix[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_random_item();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
